>>> hdl/six_button_pad_select_sequencer_assert.svh
// Assertion macros for the six-button pad select sequencer.
`ifndef SIX_BUTTON_PAD_SELECT_SEQUENCER_ASSERT_SVH
`define SIX_BUTTON_PAD_SELECT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/sbps_pkg.sv
// Package for the six-button pad select sequencer: phases, register indexes, defaults.
`timescale 1ns / 1ps

package sbps_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SETTLE_TICKS  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCK_THREE    = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd20000;
    localparam logic [7:0]  SETTLE_TICKS_RESET  = 8'd6;

    typedef enum logic [2:0] {
        PH_AWAIT_LOW_START = 3'd0,
        PH_AWAIT_FIRST_RISE = 3'd1,
        PH_AWAIT_LOW_A     = 3'd2,
        PH_AWAIT_HIGH_A    = 3'd3,
        PH_AWAIT_LOW_FORCE = 3'd4,
        PH_AWAIT_HIGH_EXTRA = 3'd5,
        PH_AWAIT_LOW_HIGH  = 3'd6,
        PH_AWAIT_TIMEOUT   = 3'd7
    } phase_t;

endpackage

>>> hdl/six_button_pad_select_sequencer.sv
// Six-button pad select sequencer: select-line edge tracker driving the pad-side outputs.
// Latency: a request's result is valid the cycle after the request is accepted.
// Throughput: one request per cycle while results are taken; state update and result compute
//   sit in one pass between the state registers, which double as the result register.
// A new request is taken while a result waits only if that result is taken the same cycle.
// Reset (rst_n low, asynchronous): phase 0, counters and flags clear, three-button outputs,
//   configuration back to timeout 20000, settle 6, lock off. No clearing pass.
`timescale 1ns / 1ps
`include "six_button_pad_select_sequencer_assert.svh"

module six_button_pad_select_sequencer #(
    parameter int TIMER_BITS = sbps_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample request channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               select_level,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               mux_select,
    output logic                               enable_n,
    output logic                               nibble_drive,
    output logic                               nibble_level,
    output logic                               timed_out,
    output logic [2:0]                         phase_now,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sbps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown indexes drop.
    // ------------------------------------------------------------------
    logic [15:0] timeout_ticks_reg;
    logic [7:0]  settle_ticks_reg;
    logic        lock_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= sbps_pkg::TIMEOUT_TICKS_RESET;
            settle_ticks_reg  <= sbps_pkg::SETTLE_TICKS_RESET;
            lock_reg          <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sbps_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                sbps_pkg::CFG_SETTLE_TICKS:  settle_ticks_reg  <= cfg_data[7:0];
                sbps_pkg::CFG_LOCK_THREE:    lock_reg          <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state. The state registers hold the values after the last
    // accepted sample, which is exactly the result payload, so they also
    // serve as the result register.
    // ------------------------------------------------------------------
    sbps_pkg::phase_t        phase_reg, phase_next;
    logic [7:0]              settle_count_reg, settle_count_next;
    logic [TIMER_BITS-1:0]   timer_count_reg, timer_count_next;
    logic                    timer_running_reg, timer_running_next;
    logic                    timeout_flag_reg, timeout_flag_next;
    logic                    select_reg, select_next;
    logic                    enable_n_reg, enable_n_next;
    logic                    drive_reg, drive_next;
    logic                    level_reg, level_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    accept;
    logic [31:0]             limit_wide;
    logic [TIMER_BITS-1:0]   limit;

    // Result slot is free, or being emptied this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Timeout limit: register value masked to the timer width.
    assign limit_wide = 32'(timeout_ticks_reg);
    assign limit      = limit_wide[TIMER_BITS-1:0];

    always_comb
    begin
        phase_next         = phase_reg;
        settle_count_next  = settle_count_reg;
        timer_count_next   = timer_count_reg;
        timer_running_next = timer_running_reg;
        timeout_flag_next  = timeout_flag_reg;
        select_next        = select_reg;
        enable_n_next      = enable_n_reg;
        drive_next         = drive_reg;
        level_next         = level_reg;

        if (lock_reg)
        begin
            // Frozen in three-button mode; timeout flag and count are kept.
            select_next        = 1'b0;
            enable_n_next      = 1'b0;
            drive_next         = 1'b0;
            level_next         = 1'b0;
            phase_next         = sbps_pkg::PH_AWAIT_LOW_START;
            settle_count_next  = 8'd0;
            timer_running_next = 1'b0;
        end
        else
        begin
            // Timer advances first; expiry drops the mux outputs at once.
            if (timer_running_reg)
            begin
                timer_count_next = timer_count_reg + TIMER_BITS'(1);
                if (timer_count_next >= limit)
                begin
                    timeout_flag_next  = 1'b1;
                    timer_running_next = 1'b0;
                    drive_next         = 1'b0;
                    select_next        = 1'b0;
                    enable_n_next      = 1'b0;
                end
            end

            if (phase_reg == sbps_pkg::PH_AWAIT_TIMEOUT)
            begin
                if (timeout_flag_next)
                begin
                    select_next       = 1'b0;
                    enable_n_next     = 1'b0;
                    drive_next        = 1'b0;
                    level_next        = 1'b0;
                    phase_next        = sbps_pkg::PH_AWAIT_LOW_START;
                    settle_count_next = 8'd0;
                end
            end
            else if (settle_count_reg < settle_ticks_reg)
            begin
                settle_count_next = settle_count_reg + 8'd1;
            end
            else if (select_level == phase_reg[0])
            begin
                // Odd phases wait for high, even phases for low.
                settle_count_next = 8'd0;
                case (phase_reg)
                    sbps_pkg::PH_AWAIT_LOW_START:
                    begin
                        phase_next = sbps_pkg::PH_AWAIT_FIRST_RISE;
                    end
                    sbps_pkg::PH_AWAIT_FIRST_RISE:
                    begin
                        timeout_flag_next  = 1'b0;
                        timer_count_next   = '0;
                        timer_running_next = 1'b1;
                        phase_next         = sbps_pkg::PH_AWAIT_LOW_A;
                    end
                    sbps_pkg::PH_AWAIT_LOW_A,
                    sbps_pkg::PH_AWAIT_HIGH_A:
                    begin
                        if (timeout_flag_next)
                        begin
                            select_next   = 1'b0;
                            enable_n_next = 1'b0;
                            drive_next    = 1'b0;
                            level_next    = 1'b0;
                            phase_next    = sbps_pkg::PH_AWAIT_LOW_START;
                        end
                        else
                        begin
                            phase_next = sbps_pkg::phase_t'(phase_reg + 3'd1);
                        end
                    end
                    sbps_pkg::PH_AWAIT_LOW_FORCE:
                    begin
                        // Recognition phase: drive the nibble low.
                        enable_n_next = 1'b1;
                        drive_next    = 1'b1;
                        select_next   = 1'b1;
                        if (timeout_flag_next)
                        begin
                            select_next   = 1'b0;
                            enable_n_next = 1'b0;
                            drive_next    = 1'b0;
                            level_next    = 1'b0;
                            phase_next    = sbps_pkg::PH_AWAIT_LOW_START;
                        end
                        else
                        begin
                            phase_next = sbps_pkg::PH_AWAIT_HIGH_EXTRA;
                        end
                    end
                    sbps_pkg::PH_AWAIT_HIGH_EXTRA:
                    begin
                        // Extra buttons through the mux.
                        drive_next    = 1'b0;
                        enable_n_next = 1'b0;
                        level_next    = 1'b1;
                        if (timeout_flag_next)
                        begin
                            select_next   = 1'b0;
                            enable_n_next = 1'b0;
                            drive_next    = 1'b0;
                            level_next    = 1'b0;
                            phase_next    = sbps_pkg::PH_AWAIT_LOW_START;
                        end
                        else
                        begin
                            phase_next = sbps_pkg::PH_AWAIT_LOW_HIGH;
                        end
                    end
                    default:
                    begin
                        // Force the nibble high, even if the timer just expired.
                        enable_n_next = 1'b1;
                        drive_next    = 1'b1;
                        select_next   = 1'b0;
                        phase_next    = sbps_pkg::PH_AWAIT_TIMEOUT;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= sbps_pkg::PH_AWAIT_LOW_START;
            settle_count_reg  <= 8'd0;
            timer_count_reg   <= '0;
            timer_running_reg <= 1'b0;
            timeout_flag_reg  <= 1'b0;
            select_reg        <= 1'b0;
            enable_n_reg      <= 1'b0;
            drive_reg         <= 1'b0;
            level_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg         <= phase_next;
                settle_count_reg  <= settle_count_next;
                timer_count_reg   <= timer_count_next;
                timer_running_reg <= timer_running_next;
                timeout_flag_reg  <= timeout_flag_next;
                select_reg        <= select_next;
                enable_n_reg      <= enable_n_next;
                drive_reg         <= drive_next;
                level_reg         <= level_next;
            end
        end
    end

    // Result payload straight from the state registers; they only move on
    // an accepted request, which needs the result slot free.
    assign out_valid    = out_valid_reg;
    assign mux_select   = select_reg;
    assign enable_n     = enable_n_reg;
    assign nibble_drive = drive_reg;
    assign nibble_level = level_reg;
    assign timed_out    = timeout_flag_reg;
    assign phase_now    = phase_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic seq_armed;
    logic lock_clean;

    // Past the first rising edge.
    assign seq_armed  = (phase_reg != sbps_pkg::PH_AWAIT_LOW_START)
                     && (phase_reg != sbps_pkg::PH_AWAIT_FIRST_RISE);
    assign lock_clean = (phase_reg == sbps_pkg::PH_AWAIT_LOW_START) && !select_reg
                     && !drive_reg && !level_reg && !timer_running_reg;

    `SBPS_ASSERT_IMPL(a_run_no_flag, timer_running_reg, !timeout_flag_reg, "timer on, flag set")
    `SBPS_ASSERT_IMPL(a_drive_tracks_en, 1'b1, drive_reg == enable_n_reg, "drive/enable_n split")
    `SBPS_ASSERT_IMPL(a_run_phase, timer_running_reg, seq_armed, "timer on before first rise")
    `SBPS_ASSERT_NEXT(a_lock_three, accept && lock_reg, lock_clean, "lock not three-button")

endmodule
